FILE: rtl/uhpse_pkg.sv
package uhpse_pkg;

  localparam int NUM_PORTS = 4;
  localparam int PIDX_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam logic [PIDX_W-1:0] LAST_PIDX = PIDX_W'(NUM_PORTS - 1);

  localparam logic [15:0] RESET_TICKS_DEF = 16'd50;

  // item opcodes
  typedef enum logic [2:0] {
    F_GET_STATUS = 3'd0,
    F_CLEAR_FEAT = 3'd1,
    F_SET_FEAT   = 3'd2,
    F_CONNECT    = 3'd3,
    F_DISCONNECT = 3'd4,
    F_OVERCUR    = 3'd5,
    F_TICK       = 3'd6
  } func_t;

  // register indexes
  localparam logic REG_RESET_TICKS    = 1'b0;
  localparam logic REG_POWER_SWITCHED = 1'b1;

  // feature selectors
  localparam logic [4:0] FEAT_C_HUB_LOCAL_POWER = 5'd0;
  localparam logic [4:0] FEAT_C_HUB_OVERCUR     = 5'd1;
  localparam logic [4:0] FEAT_PORT_RESET        = 5'd4;
  localparam logic [4:0] FEAT_PORT_POWER        = 5'd8;
  localparam logic [4:0] FEAT_C_PORT_FIRST      = 5'd16;
  localparam logic [4:0] FEAT_C_PORT_LAST       = 5'd21;
  localparam logic [4:0] FEAT_C_PORT_LINK       = 5'd23;

  // status / change bit positions
  localparam int ST_CONNECT = 0;
  localparam int ST_ENABLE  = 1;
  localparam int ST_OVERCUR = 3;
  localparam int ST_RESET   = 4;
  localparam int ST_POWER   = 8;
  localparam int ST_LOW     = 9;
  localparam int ST_HIGH    = 10;
  localparam int HUB_ST_OC  = 1;

  localparam int CH_CONNECT = 0;
  localparam int CH_ENABLE  = 1;
  localparam int CH_OVERCUR = 3;
  localparam int CH_RESET   = 4;
  localparam int CH_LINK    = 5;

  localparam int HUB_CH_OC  = 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_TICK,
    S_REPORT
  } seq_state_t;

endpackage

FILE: rtl/usb_hub_port_status_engine.sv
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    func, port_number, feature,
//                                             attach_speed, overcurrent_level
// out_      result     out_valid / out_ready  port_status, port_change,
//                                             request_ok, change_bitmap
// cfg (APB) write/read psel, penable, pready  paddr, pwdata, prdata
//
// Sequence: a request is applied the cycle after accept, then goes to the
//   report step, which loads its result into the output register; a tick walks
//   the reset counters through one shared decrementer, one port per cycle,
//   before its report step.
//   in_ready is high only while the sequencer is idle.
// Reset: synchronous, active low; all port and hub state cleared,
//   reset_ticks = 50, power_switched = 1.
// Stalls: a finished result waits in the output register; the sequencer
//   holds in its report step until that register is free, while a new
//   request may already be taken once the sequencer is back to idle.
module usb_hub_port_status_engine
  import uhpse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_port_number,
  input  logic [4:0]  in_feature,
  input  logic [1:0]  in_attach_speed,
  input  logic        in_overcurrent_level,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_port_status,
  output logic [5:0]  out_port_change,
  output logic        out_request_ok,
  output logic [15:0] out_change_bitmap,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [15:0] reset_ticks_r;
  logic        power_switched_r;
  logic        cfg_wr;

  // sequencer
  seq_state_t        state_r, state_nxt;
  logic [PIDX_W-1:0] tick_idx_r, tick_idx_nxt;
  logic              accept;
  logic              out_load;

  // captured request
  func_t       func_r;
  logic [3:0]  port_r;
  logic [4:0]  feature_r;
  logic [1:0]  speed_r;
  logic        level_r;
  logic        ok_r, ok_nxt;

  // per-port state
  logic [NUM_PORTS-1:0] powered_r,   powered_nxt;
  logic [NUM_PORTS-1:0] connected_r, connected_nxt;
  logic [NUM_PORTS-1:0] enabled_r,   enabled_nxt;
  logic [NUM_PORTS-1:0] in_reset_r,  in_reset_nxt;
  logic [NUM_PORTS-1:0] overcur_r,   overcur_nxt;
  logic [1:0]           speed_st_r   [NUM_PORTS];
  logic [1:0]           speed_st_nxt [NUM_PORTS];
  logic [5:0]           chg_r        [NUM_PORTS];
  logic [5:0]           chg_nxt      [NUM_PORTS];
  logic [15:0]          cnt_r        [NUM_PORTS];
  logic [15:0]          cnt_nxt      [NUM_PORTS];

  logic       hub_oc_r,  hub_oc_nxt;
  logic [1:0] hub_chg_r, hub_chg_nxt;

  // addressed port
  logic [3:0]        port_m1;
  logic [PIDX_W-1:0] req_idx;
  logic [PIDX_W-1:0] tgt_idx;
  logic              port_ok;
  logic              is_hub;
  logic              tgt_power;
  logic [15:0]       reload;
  logic [15:0]       dec_val;
  logic [2:0]        clr_sel;

  // result
  logic [15:0] res_status;
  logic [5:0]  res_change;
  logic [15:0] res_bitmap;

  logic        out_valid_r;
  logic [15:0] out_status_r;
  logic [5:0]  out_change_r;
  logic        out_ok_r;
  logic [15:0] out_bitmap_r;

  //--------------------------------------------------------------------
  // APB config port: register i at byte address 4*i
  //--------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_ticks_r    <= RESET_TICKS_DEF;
      power_switched_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RESET_TICKS:    reset_ticks_r    <= pwdata[15:0];
        REG_POWER_SWITCHED: power_switched_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RESET_TICKS:    prdata = {16'd0, reset_ticks_r};
      REG_POWER_SWITCHED: prdata = {31'd0, power_switched_r};
      default:            prdata = 32'd0;
    endcase
  end

  //--------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_REPORT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (func_t'(in_func) == F_TICK) ? S_TICK : S_APPLY;
        end
      end
      S_APPLY: state_nxt = S_REPORT;
      S_TICK: begin
        if (tick_idx_r == LAST_PIDX) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    tick_idx_nxt = tick_idx_r;
    unique case (state_r)
      S_IDLE:   tick_idx_nxt = '0;
      S_TICK:   tick_idx_nxt = tick_idx_r + 1'b1;
      S_APPLY:  tick_idx_nxt = tick_idx_r;
      S_REPORT: tick_idx_nxt = tick_idx_r;
      default:  tick_idx_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      tick_idx_r <= '0;
      ok_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_idx_r <= tick_idx_nxt;
      ok_r       <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= func_t'(in_func);
      port_r    <= in_port_number;
      feature_r <= in_feature;
      speed_r   <= in_attach_speed;
      level_r   <= in_overcurrent_level;
    end
  end

  //--------------------------------------------------------------------
  // Shared per-port update unit: one port touched per cycle
  //--------------------------------------------------------------------
  assign port_m1   = port_r - 4'd1;
  assign req_idx   = port_m1[PIDX_W-1:0];
  assign port_ok   = (port_r <= 4'(NUM_PORTS));
  assign is_hub    = (port_r == 4'd0);
  assign tgt_idx   = (state_r == S_TICK) ? tick_idx_r : req_idx;
  assign tgt_power = !power_switched_r || powered_r[tgt_idx];
  assign reload    = (reset_ticks_r != 16'd0) ? reset_ticks_r : 16'd1;
  assign dec_val   = (cnt_r[tgt_idx] != 16'd0) ? (cnt_r[tgt_idx] - 16'd1) : 16'd0;
  assign clr_sel   = (feature_r == FEAT_C_PORT_LINK) ? 3'(CH_LINK)
                                                     : feature_r[2:0] - 3'd0;

  always_comb begin
    powered_nxt   = powered_r;
    connected_nxt = connected_r;
    enabled_nxt   = enabled_r;
    in_reset_nxt  = in_reset_r;
    overcur_nxt   = overcur_r;
    speed_st_nxt  = speed_st_r;
    chg_nxt       = chg_r;
    cnt_nxt       = cnt_r;
    hub_oc_nxt    = hub_oc_r;
    hub_chg_nxt   = hub_chg_r;
    ok_nxt        = ok_r;

    unique case (state_r)
      S_TICK: begin
        ok_nxt = 1'b1;
        if (in_reset_r[tgt_idx]) begin
          cnt_nxt[tgt_idx] = dec_val;
          if (dec_val == 16'd0) begin
            in_reset_nxt[tgt_idx]           = 1'b0;
            enabled_nxt[tgt_idx]            = 1'b1;
            chg_nxt[tgt_idx][CH_RESET]      = 1'b1;
          end
        end
      end

      S_APPLY: begin
        ok_nxt = 1'b0;
        if (!port_ok) begin
          ok_nxt = 1'b0;
        end else if (is_hub) begin
          unique case (func_r)
            F_GET_STATUS: ok_nxt = 1'b1;
            F_CLEAR_FEAT: begin
              if (feature_r == FEAT_C_HUB_LOCAL_POWER ||
                  feature_r == FEAT_C_HUB_OVERCUR) begin
                hub_chg_nxt[feature_r[0]] = 1'b0;
                ok_nxt = 1'b1;
              end
            end
            F_OVERCUR: begin
              if (hub_oc_r != level_r) begin
                hub_chg_nxt[HUB_CH_OC] = 1'b1;
              end
              hub_oc_nxt = level_r;
              ok_nxt     = 1'b1;
            end
            default: ok_nxt = 1'b0;
          endcase
        end else begin
          unique case (func_r)
            F_GET_STATUS: ok_nxt = 1'b1;
            F_CLEAR_FEAT: begin
              // change-bit clears: 16..21 map to bits 0..5, 23 to link state
              if ((feature_r >= FEAT_C_PORT_FIRST && feature_r <= FEAT_C_PORT_LAST) ||
                  feature_r == FEAT_C_PORT_LINK) begin
                chg_nxt[tgt_idx] = chg_r[tgt_idx] & ~(6'd1 << clr_sel);
                ok_nxt = 1'b1;
              end
            end
            F_SET_FEAT: begin
              if (feature_r == FEAT_PORT_POWER) begin
                powered_nxt[tgt_idx] = 1'b1;
                ok_nxt = 1'b1;
              end else if (feature_r == FEAT_PORT_RESET) begin
                if (connected_r[tgt_idx] && tgt_power) begin
                  enabled_nxt[tgt_idx]  = 1'b0;
                  in_reset_nxt[tgt_idx] = 1'b1;
                  cnt_nxt[tgt_idx]      = reload;
                end
                ok_nxt = 1'b1;
              end
            end
            F_CONNECT: begin
              if (!connected_r[tgt_idx]) begin
                chg_nxt[tgt_idx][CH_CONNECT] = 1'b1;
              end
              connected_nxt[tgt_idx] = 1'b1;
              speed_st_nxt[tgt_idx]  = (speed_r > 2'd2) ? 2'd2 : speed_r;
              ok_nxt = 1'b1;
            end
            F_DISCONNECT: begin
              if (connected_r[tgt_idx]) begin
                chg_nxt[tgt_idx][CH_CONNECT] = 1'b1;
              end
              connected_nxt[tgt_idx] = 1'b0;
              speed_st_nxt[tgt_idx]  = 2'd0;
              enabled_nxt[tgt_idx]   = 1'b0;
              in_reset_nxt[tgt_idx]  = 1'b0;
              cnt_nxt[tgt_idx]       = 16'd0;
              ok_nxt = 1'b1;
            end
            F_OVERCUR: begin
              if (overcur_r[tgt_idx] != level_r) begin
                chg_nxt[tgt_idx][CH_OVERCUR] = 1'b1;
              end
              overcur_nxt[tgt_idx] = level_r;
              if (level_r) begin
                // power loss drops enable and any reset in flight
                if (enabled_r[tgt_idx]) begin
                  chg_nxt[tgt_idx][CH_ENABLE] = 1'b1;
                end
                powered_nxt[tgt_idx]  = 1'b0;
                enabled_nxt[tgt_idx]  = 1'b0;
                in_reset_nxt[tgt_idx] = 1'b0;
                cnt_nxt[tgt_idx]      = 16'd0;
              end
              ok_nxt = 1'b1;
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end

      S_IDLE:   ;
      S_REPORT: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r   <= '0;
      connected_r <= '0;
      enabled_r   <= '0;
      in_reset_r  <= '0;
      overcur_r   <= '0;
      hub_oc_r    <= 1'b0;
      hub_chg_r   <= 2'd0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        speed_st_r[i] <= 2'd0;
        chg_r[i]      <= 6'd0;
        cnt_r[i]      <= 16'd0;
      end
    end else begin
      powered_r   <= powered_nxt;
      connected_r <= connected_nxt;
      enabled_r   <= enabled_nxt;
      in_reset_r  <= in_reset_nxt;
      overcur_r   <= overcur_nxt;
      hub_oc_r    <= hub_oc_nxt;
      hub_chg_r   <= hub_chg_nxt;
      speed_st_r  <= speed_st_nxt;
      chg_r       <= chg_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  //--------------------------------------------------------------------
  // Result formatting
  //--------------------------------------------------------------------
  always_comb begin
    res_status = 16'd0;
    res_change = 6'd0;
    if (ok_r && port_ok) begin
      if (is_hub) begin
        res_status[HUB_ST_OC] = hub_oc_r;
        res_change            = {4'd0, hub_chg_r};
      end else begin
        if (connected_r[req_idx]) begin
          res_status[ST_CONNECT] = 1'b1;
          res_status[ST_LOW]     = (speed_st_r[req_idx] == 2'd0);
          res_status[ST_HIGH]    = (speed_st_r[req_idx] >= 2'd2);
        end
        res_status[ST_ENABLE]  = enabled_r[req_idx];
        res_status[ST_OVERCUR] = overcur_r[req_idx];
        res_status[ST_RESET]   = in_reset_r[req_idx];
        res_status[ST_POWER]   = !power_switched_r || powered_r[req_idx];
        res_change             = chg_r[req_idx];
      end
    end
  end

  always_comb begin
    res_bitmap    = 16'd0;
    res_bitmap[0] = (hub_chg_r != 2'd0);
    for (int i = 0; i < NUM_PORTS; i++) begin
      res_bitmap[i+1] = (chg_r[i] != 6'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_change_r <= res_change;
      out_ok_r     <= ok_r;
      out_bitmap_r <= res_bitmap;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_port_status   = out_status_r;
  assign out_port_change   = out_change_r;
  assign out_request_ok    = out_ok_r;
  assign out_change_bitmap = out_bitmap_r;

`ifndef SYNTHESIS
  // a port never reports enabled while its reset is still running
  a_enable_vs_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (enabled_r & in_reset_r) == '0)
    else $error("port enabled during reset");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accept");

  // port status only moves while a request is being applied
  a_chg_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_REPORT) |=>
      ($stable(connected_r) && $stable(in_reset_r) && $stable(enabled_r)))
    else $error("port status moved outside apply/tick");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // tick sweep ends by reporting
  a_tick_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && tick_idx_r == LAST_PIDX) |=> state_r == S_REPORT)
    else $error("tick sweep did not finish");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import uhpse_pkg::*;

  // func code 7 has no meaning and is answered with request_ok low
  localparam logic [2:0] FUNC_UNDEFINED = 3'd7;
  // cycles without any accepted request or result before the run is abandoned
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [3:0]  in_port_number;
  logic [4:0]  in_feature;
  logic [1:0]  in_attach_speed;
  logic        in_overcurrent_level;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_port_status;
  logic [5:0]  out_port_change;
  logic        out_request_ok;
  logic [15:0] out_change_bitmap;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // idle odds in percent, set per phase
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  typedef struct {
    logic [15:0] status;
    logic [5:0]  change;
    logic        ok;
    logic [15:0] bitmap;
  } port_reply_t;

  // Tracks hub and port state as the host would see it, and holds the
  // replies still owed by the block, oldest first.
  class port_status_scoreboard;
    logic [15:0] reset_ticks;
    logic        power_switched;
    logic        powered   [NUM_PORTS];
    logic        connected [NUM_PORTS];
    logic        enabled   [NUM_PORTS];
    logic        in_reset  [NUM_PORTS];
    logic        overcur   [NUM_PORTS];
    logic [1:0]  speed     [NUM_PORTS];
    logic [5:0]  chg       [NUM_PORTS];
    logic [15:0] countdown [NUM_PORTS];
    logic        hub_overcur;
    logic [1:0]  hub_chg;
    port_reply_t expected_replies[$];
    int          fails;

    function new();
      reset_ticks = RESET_TICKS_DEF;
      power_switched = 1'b1;
      for (int i = 0; i < NUM_PORTS; i++) begin
        powered[i] = 1'b0;
        connected[i] = 1'b0;
        enabled[i] = 1'b0;
        in_reset[i] = 1'b0;
        overcur[i] = 1'b0;
        speed[i] = 2'd0;
        chg[i] = 6'd0;
        countdown[i] = 16'd0;
      end
      hub_overcur = 1'b0;
      hub_chg = 2'd0;
      fails = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report(string what);
      fails++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_RESET_TICKS) reset_ticks = value[15:0];
      else power_switched = value[0];
    endfunction

    function logic has_power(int i);
      return !power_switched || powered[i];
    endfunction

    function void drop_enable(int i);
      enabled[i] = 1'b0;
      in_reset[i] = 1'b0;
      countdown[i] = 16'd0;
    endfunction

    function logic [15:0] port_word(int i);
      logic [15:0] w;
      w = '0;
      if (connected[i]) begin
        w[ST_CONNECT] = 1'b1;
        if (speed[i] == 2'd0) w[ST_LOW] = 1'b1;
        else if (speed[i] >= 2'd2) w[ST_HIGH] = 1'b1;
      end
      w[ST_ENABLE]  = enabled[i];
      w[ST_OVERCUR] = overcur[i];
      w[ST_RESET]   = in_reset[i];
      w[ST_POWER]   = has_power(i);
      return w;
    endfunction

    function logic port_request(logic [2:0] func, int i, logic [4:0] feat,
                                logic [1:0] spd, logic lvl);
      case (func)
        F_GET_STATUS: return 1'b1;
        F_CLEAR_FEAT: begin
          if (feat >= FEAT_C_PORT_FIRST && feat <= FEAT_C_PORT_LAST) begin
            chg[i][feat - FEAT_C_PORT_FIRST] = 1'b0;
            return 1'b1;
          end
          if (feat == FEAT_C_PORT_LINK) begin
            chg[i][CH_LINK] = 1'b0;
            return 1'b1;
          end
          return 1'b0;
        end
        F_SET_FEAT: begin
          if (feat == FEAT_PORT_POWER) begin
            powered[i] = 1'b1;
            return 1'b1;
          end
          if (feat == FEAT_PORT_RESET) begin
            // only a connected, powered port actually enters reset
            if (connected[i] && has_power(i)) begin
              enabled[i] = 1'b0;
              in_reset[i] = 1'b1;
              countdown[i] = (reset_ticks != 16'd0) ? reset_ticks : 16'd1;
            end
            return 1'b1;
          end
          return 1'b0;
        end
        F_CONNECT: begin
          if (!connected[i]) chg[i][CH_CONNECT] = 1'b1;
          connected[i] = 1'b1;
          speed[i] = (spd > 2'd2) ? 2'd2 : spd;
          return 1'b1;
        end
        F_DISCONNECT: begin
          if (connected[i]) chg[i][CH_CONNECT] = 1'b1;
          connected[i] = 1'b0;
          speed[i] = 2'd0;
          drop_enable(i);
          return 1'b1;
        end
        F_OVERCUR: begin
          if (overcur[i] != lvl) chg[i][CH_OVERCUR] = 1'b1;
          overcur[i] = lvl;
          if (lvl) begin
            if (enabled[i]) chg[i][CH_ENABLE] = 1'b1;
            powered[i] = 1'b0;
            drop_enable(i);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function logic hub_apply(logic [2:0] func, logic [4:0] feat, logic lvl);
      case (func)
        F_GET_STATUS: return 1'b1;
        F_CLEAR_FEAT: begin
          if (feat <= FEAT_C_HUB_OVERCUR) begin
            hub_chg[feat[0]] = 1'b0;
            return 1'b1;
          end
          return 1'b0;
        end
        F_OVERCUR: begin
          if (hub_overcur != lvl) hub_chg[HUB_CH_OC] = 1'b1;
          hub_overcur = lvl;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Applies one accepted request and queues the reply it must produce.
    function void note_request(logic [2:0] func, logic [3:0] pnum, logic [4:0] feat,
                               logic [1:0] spd, logic lvl);
      port_reply_t r;
      logic known;
      known = (pnum <= NUM_PORTS);
      r.status = '0;
      r.change = '0;
      r.bitmap = '0;
      if (func == F_TICK) begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          if (in_reset[i]) begin
            if (countdown[i] != 16'd0) countdown[i]--;
            if (countdown[i] == 16'd0) begin
              in_reset[i] = 1'b0;
              enabled[i] = 1'b1;
              chg[i][CH_RESET] = 1'b1;
            end
          end
        end
        r.ok = 1'b1;
      end else if (!known) begin
        r.ok = 1'b0;
      end else if (pnum == 4'd0) begin
        r.ok = hub_apply(func, feat, lvl);
      end else begin
        r.ok = port_request(func, pnum - 1, feat, spd, lvl);
      end
      // a tick to a bad port is accepted but reports zeros
      if (r.ok && known) begin
        if (pnum == 4'd0) begin
          r.status[HUB_ST_OC] = hub_overcur;
          r.change = {4'd0, hub_chg};
        end else begin
          r.status = port_word(pnum - 1);
          r.change = chg[pnum - 1];
        end
      end
      r.bitmap[0] = (hub_chg != 2'd0);
      for (int i = 0; i < NUM_PORTS; i++)
        if (chg[i] != 6'd0) r.bitmap[i + 1] = 1'b1;
      expected_replies.push_back(r);
    endfunction

    task check_reply(logic [15:0] status, logic [5:0] change, logic ok,
                     logic [15:0] bitmap);
      port_reply_t r;
      if (expected_replies.size() == 0) begin
        report($sformatf("result with none expected (status %h)", status));
        return;
      end
      r = expected_replies.pop_front();
      if (status !== r.status)
        report($sformatf("port_status got %h want %h", status, r.status));
      if (change !== r.change)
        report($sformatf("port_change got %h want %h", change, r.change));
      if (ok !== r.ok)
        report($sformatf("request_ok got %b want %b", ok, r.ok));
      if (bitmap !== r.bitmap)
        report($sformatf("change_bitmap got %h want %h", bitmap, r.bitmap));
    endtask
  endclass

  port_status_scoreboard sb = new();

  usb_hub_port_status_engine u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_port_number       (in_port_number),
    .in_feature           (in_feature),
    .in_attach_speed      (in_attach_speed),
    .in_overcurrent_level (in_overcurrent_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_port_status      (out_port_status),
    .out_port_change      (out_port_change),
    .out_request_ok       (out_request_ok),
    .out_change_bitmap    (out_change_bitmap),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // every accepted result is checked against the oldest owed reply
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply(out_port_status, out_port_change, out_request_ok, out_change_bitmap);
  end

  // Drives one request at the falling edge, optionally after random idle
  // cycles, and holds it until the block takes it. valid stays high across
  // back-to-back requests.
  task automatic send_request(input logic [2:0] func, input logic [3:0] pnum,
                              input logic [4:0] feat, input logic [1:0] spd,
                              input logic lvl);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = func;
    in_port_number = pnum;
    in_feature = feat;
    in_attach_speed = spd;
    in_overcurrent_level = lvl;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(func, pnum, feat, spd, lvl);
  endtask

  // Mostly sensible traffic on real ports (power, attach, reset, ticks,
  // change acks) with some bad ports, bad features and undefined codes.
  task automatic send_random_request();
    logic [2:0]  func;
    logic [3:0]  pnum;
    logic [4:0]  feat;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) func = F_TICK;
    else if (r < 42) func = F_GET_STATUS;
    else if (r < 57) func = F_SET_FEAT;
    else if (r < 72) func = F_CLEAR_FEAT;
    else if (r < 82) func = F_CONNECT;
    else if (r < 89) func = F_DISCONNECT;
    else if (r < 95) func = F_OVERCUR;
    else if (r < 97) func = FUNC_UNDEFINED;
    else func = 3'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 10) pnum = 4'd0;
    else if (r < 88) pnum = 4'($urandom_range(NUM_PORTS, 1));
    else pnum = 4'($urandom_range(15));
    feat = 5'($urandom_range(31));
    if ($urandom_range(99) < 85) begin
      if (func == F_SET_FEAT) begin
        feat = $urandom_range(1) ? FEAT_PORT_POWER : FEAT_PORT_RESET;
      end else if (func == F_CLEAR_FEAT) begin
        if (pnum == 4'd0)
          feat = $urandom_range(1) ? FEAT_C_HUB_OVERCUR : FEAT_C_HUB_LOCAL_POWER;
        else if ($urandom_range(6) == 0)
          feat = FEAT_C_PORT_LINK;
        else
          feat = FEAT_C_PORT_FIRST + 5'($urandom_range(5));
      end
    end
    send_request(func, pnum, feat, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // APB write, then a read back of the same register
  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (idx == REG_RESET_TICKS) begin
      if (readback[15:0] !== value[15:0])
        sb.report($sformatf("reset_ticks read %h want %h", readback[15:0], value[15:0]));
    end else if (readback[0] !== value[0]) begin
      sb.report($sformatf("power_switched read %b want %b", readback[0], value[0]));
    end
  endtask

  // drain: all replies in, then a wait for any tick still walking ports
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_PORTS + 4) @(posedge clk);
  endtask

  // Gives up when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    // per phase: reset length, power switching, sender idle %, receiver stall %, requests
    int unsigned ph_ticks[6] = '{1, 3, 0, 65535, 50, 2};
    logic        ph_switch[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int          ph_send[6]   = '{0, 60, 0, 36, 0, 36};
    int          ph_recv[6]   = '{0, 0, 60, 36, 0, 36};
    int          ph_count[6]  = '{150, 150, 150, 100, 150, 125};

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_port_number = '0;
    in_feature = '0;
    in_attach_speed = '0;
    in_overcurrent_level = 1'b0;
    out_ready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset defaults (50 ticks, switched power).
    // Hub target: status, overcurrent edges, change acks, illegal requests.
    send_request(F_GET_STATUS, 4'd0, 5'd0, 2'd0, 1'b0);
    send_request(F_OVERCUR, 4'd0, 5'd0, 2'd0, 1'b1);
    send_request(F_OVERCUR, 4'd0, 5'd0, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd0, FEAT_C_HUB_OVERCUR, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd0, FEAT_C_HUB_LOCAL_POWER, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd0, 5'd2, 2'd0, 1'b0);
    send_request(F_SET_FEAT, 4'd0, FEAT_PORT_POWER, 2'd0, 1'b0);
    send_request(F_CONNECT, 4'd0, 5'd0, 2'd2, 1'b0);
    send_request(F_DISCONNECT, 4'd0, 5'd0, 2'd0, 1'b0);
    // bad port gets request_ok low, but a tick to any port is fine and reports zeros
    send_request(F_GET_STATUS, 4'(NUM_PORTS + 1), 5'd0, 2'd0, 1'b0);
    send_request(F_TICK, 4'd15, 5'd31, 2'd3, 1'b1);
    send_request(FUNC_UNDEFINED, 4'd1, 5'd0, 2'd0, 1'b0);
    // reset on an unpowered, empty port does nothing but is accepted
    send_request(F_SET_FEAT, 4'd1, FEAT_PORT_RESET, 2'd0, 1'b0);
    send_request(F_SET_FEAT, 4'd1, FEAT_PORT_POWER, 2'd0, 1'b0);
    // speed code 3 maps to high; a second connect raises no change
    send_request(F_CONNECT, 4'd1, 5'd0, 2'd3, 1'b0);
    send_request(F_CONNECT, 4'd1, 5'd0, 2'd0, 1'b0);
    send_request(F_SET_FEAT, 4'd1, FEAT_PORT_RESET, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd1, FEAT_C_PORT_FIRST, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd1, FEAT_C_PORT_LINK, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'd1, 5'd22, 2'd0, 1'b0);
    send_request(F_SET_FEAT, 4'd1, 5'd31, 2'd0, 1'b0);
    // overcurrent in the middle of a reset kills power and the reset
    send_request(F_OVERCUR, 4'd1, 5'd0, 2'd0, 1'b1);
    // disconnect of an empty port sets no change; a real one does
    send_request(F_DISCONNECT, 4'(NUM_PORTS), 5'd0, 2'd0, 1'b0);
    send_request(F_CONNECT, 4'(NUM_PORTS), 5'd0, 2'd1, 1'b0);
    send_request(F_DISCONNECT, 4'(NUM_PORTS), 5'd0, 2'd0, 1'b0);
    send_request(F_CLEAR_FEAT, 4'(NUM_PORTS), FEAT_C_PORT_LAST, 2'd0, 1'b0);
    @(negedge clk);
    in_valid = 1'b0;

    // Random phases; registers change only with the block drained.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_register(REG_RESET_TICKS, 32'(ph_ticks[p]));
      write_register(REG_POWER_SWITCHED, {31'd0, ph_switch[p]});
      sender_idle_pct = ph_send[p];
      receiver_stall_pct = ph_recv[p];
      repeat (ph_count[p]) send_random_request();
      @(negedge clk);
      in_valid = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
